[rtl/rk4ls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4ls_pkg
// Shared constants and arithmetic helpers for the RK4 subsystem stepper.
// ----------------------------------------------------------------------------
package rk4ls_pkg;

    localparam int SUBSYSTEMS_DEF = 16;
    localparam int RESULT_LIMIT   = 16;
    localparam int TS_RESET       = 655;
    localparam int ACTIVE_RESET   = 16;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_ACTIVE    = 2'd1;

    // clamp a 36-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [35:0] a);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sd2147483647;
        lo = -36'sd2147483648;
        if (a > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (a < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = a[31:0];
        end
    endfunction

endpackage
`default_nettype wire

[rtl/rk4ls_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4ls_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rk4ls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/rk4ls_axis.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4ls_axis
// Sequential RK4 update of one axis (p, v) through one shared multiplier.
// ----------------------------------------------------------------------------
module rk4ls_axis (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire        [15:0] i_ts,
    input  wire signed [31:0] i_p,
    input  wire signed [31:0] i_v,
    output logic              o_done,
    output logic signed [31:0] o_p,
    output logic signed [31:0] o_v
);
    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_FIN1, S_FIN2} t_state;

    t_state             r_state;
    logic        [1:0]  r_k;
    logic signed [31:0] r_p, r_v, r_vs;
    logic signed [35:0] r_sp, r_sv;
    logic signed [31:0] r_kp;
    logic signed [35:0] r_qp, r_qv;

    logic signed [48:0] w_prod;
    logic signed [31:0] w_kp, w_kv, w_nvs;
    logic signed [35:0] w_wp, w_wv;

    // floor(a / 6) estimate, at most one low: a = hi*65536 + lo and
    // 65536 = 6*10922 + 4, so a/6 = 10922*hi + (4*hi + lo)/6
    function automatic logic signed [35:0] div6_est(input logic signed [35:0] a);
        logic signed [19:0] hi;
        logic signed [22:0] b;
        logic signed [47:0] bm;
        logic signed [35:0] qh;
        hi = a[35:16];
        b  = (23'(hi) <<< 2) + 23'($signed({1'b0, a[15:0]}));
        bm = 48'(b) * 48'sd5592406;
        qh = 36'(hi) * 36'sd10922;
        div6_est = qh + 36'(bm >>> 25);
    endfunction

    // correct an approximate quotient by at most one either way
    function automatic logic signed [35:0] fix6(input logic signed [35:0] a,
                                                input logic signed [35:0] q);
        logic signed [39:0] rem;
        rem = 40'(a) - 40'(q) * 40'sd6;
        if (rem < 0) begin
            fix6 = q - 36'sd1;
        end else if (rem >= 40'sd6) begin
            fix6 = q + 36'sd1;
        end else begin
            fix6 = q;
        end
    endfunction

    // mul(x) = floor((h*x + 32768) / 65536)
    assign w_prod = $signed({1'b0, i_ts}) * r_vs + 49'sd32768;
    assign w_kp   = w_prod[47:16];
    assign w_kv   = rk4ls_pkg::sat32(-{{4{r_kp[31]}}, r_kp});

    // weight 2 on the middle stages
    assign w_wp = (r_k == 2'd1 || r_k == 2'd2) ? {{3{r_kp[31]}}, r_kp, 1'b0}
                                             : {{4{r_kp[31]}}, r_kp};
    assign w_wv = (r_k == 2'd1 || r_k == 2'd2) ? {{3{w_kv[31]}}, w_kv, 1'b0}
                                             : {{4{w_kv[31]}}, w_kv};

    always_comb begin
        case (r_k) inside
            2'd0, 2'd1: w_nvs = rk4ls_pkg::sat32({{4{r_v[31]}}, r_v}
                                + {{5{w_kv[31]}}, w_kv[31:1]});
            default:    w_nvs = rk4ls_pkg::sat32({{4{r_v[31]}}, r_v}
                                + {{4{w_kv[31]}}, w_kv});
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= (r_state == S_FIN2);
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_p     <= i_p;
                        r_v     <= i_v;
                        r_vs    <= i_v;
                        r_sp    <= 36'sd3;
                        r_sv    <= 36'sd3;
                        r_k     <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_kp    <= w_kp;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sp <= r_sp + w_wp;
                    r_sv <= r_sv + w_wv;
                    r_vs <= w_nvs;
                    r_k  <= r_k + 2'd1;
                    r_state <= (r_k == 2'd3) ? S_FIN1 : S_MUL;
                end
                S_FIN1: begin
                    // floor division by six: estimate, then fixup
                    r_qp <= div6_est(r_sp);
                    r_qv <= div6_est(r_sv);
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    o_p <= rk4ls_pkg::sat32({{4{r_p[31]}}, r_p} + fix6(r_sp, r_qp));
                    o_v <= rk4ls_pkg::sat32({{4{r_v[31]}}, r_v} + fix6(r_sv, r_qv));
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/rk4_linear_system_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rk4_linear_system_step
// Bank of planar subsystems advanced by one RK4 step per step transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_stall): action 0 loads one subsystem's state
//   without stalling, so loads may follow back to back; action 1 steps
//   subsystems 0 .. count-1.
//   Output channel (o_valid/i_stall): one transaction per stepped subsystem,
//   in index order, with o_last on the final one.
//   Each subsystem passes through a memory read, a start strobe, the two axis
//   units running in parallel (four multiply/accumulate rounds each on a
//   single multiplier, then a divide-by-six estimate and fixup), and a
//   registered hand-off of the transaction; the next subsystem is read only
//   after that result is taken. The input stalls from a step's acceptance
//   until its last result is taken.
//   Reset: a clearing pass writes zero to every memory entry, one per cycle
//   (SUBSYSTEMS rounded up to a power of two), during which no input is
//   taken; config resets to time_step 655 and active_subsystems 16.
//   A stalled result holds its payload and halts the sweep.
// ----------------------------------------------------------------------------
module rk4_linear_system_step #(
    parameter int SUBSYSTEMS = rk4ls_pkg::SUBSYSTEMS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_action,
    input  wire  [3:0]  i_index,
    input  wire  [31:0] i_pos_x,
    input  wire  [31:0] i_pos_y,
    input  wire  [31:0] i_vel_x,
    input  wire  [31:0] i_vel_y,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [3:0]  o_subsystem,
    output logic [31:0] o_new_pos_x,
    output logic [31:0] o_new_pos_y,
    output logic [31:0] o_new_vel_x,
    output logic [31:0] o_new_vel_y,
    output logic        o_last
);
    localparam int AW    = (SUBSYSTEMS > 1) ? $clog2(SUBSYSTEMS) : 1;
    localparam int DEPTH = 1 << AW;
    localparam int LIM   = (SUBSYSTEMS < rk4ls_pkg::RESULT_LIMIT) ? SUBSYSTEMS
                                                                  : rk4ls_pkg::RESULT_LIMIT;

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_READ, S_RUN, S_WAIT, S_OUT} t_state;

    t_state      r_state;
    logic [15:0] r_ts;
    logic [4:0]  r_active;
    logic [4:0]  r_count;
    logic [AW:0] r_addr;
    logic [AW:0] r_clr;
    logic        r_start;

    logic           w_we;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [63:0]    w_wpos, w_wvel, w_rpos, w_rvel;
    logic           w_dx, w_dy;
    logic [31:0]    w_px, w_vx, w_py, w_vy;
    logic [4:0]     w_cnt;

    assign w_cnt = (r_active > 5'(LIM)) ? 5'(LIM) : r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts     <= 16'(rk4ls_pkg::TS_RESET);
            r_active <= 5'(rk4ls_pkg::ACTIVE_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rk4ls_pkg::CFG_TIME_STEP: r_ts     <= i_cfg_data;
                rk4ls_pkg::CFG_ACTIVE:    r_active <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign w_raddr = r_addr[AW-1:0];

    // write port: clearing pass, loads, then step write back
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr[AW-1:0];
        w_wpos  = {w_py, w_px};
        w_wvel  = {w_vy, w_vx};
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr[AW-1:0];
            w_wpos  = '0;
            w_wvel  = '0;
        end else if (r_state == S_IDLE && i_valid && i_action == rk4ls_pkg::ACT_LOAD) begin
            w_we    = (7'(i_index) < 7'(SUBSYSTEMS));
            w_waddr = AW'(i_index);
            w_wpos  = {i_pos_y, i_pos_x};
            w_wvel  = {i_vel_y, i_vel_x};
        end else if (r_state == S_WAIT && w_dx) begin
            w_we = 1'b1;
        end
    end

    rk4ls_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_pos (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wpos),
        .i_raddr(w_raddr), .o_rdata(w_rpos));
    rk4ls_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_vel (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wvel),
        .i_raddr(w_raddr), .o_rdata(w_rvel));

    rk4ls_axis u_ax (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_ts(r_ts),
        .i_p(w_rpos[31:0]), .i_v(w_rvel[31:0]), .o_done(w_dx), .o_p(w_px), .o_v(w_vx));
    rk4ls_axis u_ay (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_ts(r_ts),
        .i_p(w_rpos[63:32]), .i_v(w_rvel[63:32]), .o_done(w_dy), .o_p(w_py), .o_v(w_vy));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_addr  <= '0;
            r_start <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            // kick both axis units once the read data is in
            r_start <= (r_state == S_RUN);
            unique case (r_state)
                S_CLR: begin
                    // sweep every entry to zero
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && i_action == rk4ls_pkg::ACT_STEP && w_cnt != 5'd0) begin
                        r_count <= w_cnt;
                        r_addr  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_RUN;
                S_RUN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_dx && w_dy) begin
                        o_valid     <= 1'b1;
                        o_subsystem <= 4'(r_addr);
                        o_new_pos_x <= w_px;
                        o_new_pos_y <= w_py;
                        o_new_vel_x <= w_vx;
                        o_new_vel_y <= w_vy;
                        o_last      <= (5'(r_addr) + 5'd1 == r_count);
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold the result until taken
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        if (o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_addr  <= r_addr + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
